// File: hdl/msdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Message segmenting destination queues: shared package
// Types and defaults shared by the core and its testbench.
// ----------------------------------------------------------------------------
package msdq_pkg;

	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int DESTINATIONS_DEF = 4;

	localparam logic [7:0] FRAG_SIZE_RESET = 8'd20;

	localparam int LEN_W  = 10;
	localparam int NUM_W  = 16;
	localparam int FRAG_W = 8;
	localparam int DEST_W = 2;
	localparam int WORD_W = NUM_W + LEN_W;

	typedef enum logic {
		MODE_MESSAGE = 1'b0,
		MODE_TICK    = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [LEN_W-1:0]   message_length;
		logic [DEST_W-1:0]  destination;
	} item_t;

	typedef struct packed {
		logic [DEST_W-1:0]  out_destination;
		logic [NUM_W-1:0]   message_number;
		logic [FRAG_W-1:0]  fragment_length;
		logic               final_fragment;
		logic               last;
	} result_t;

endpackage : msdq_pkg
`default_nettype wire

// File: hdl/msdq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module msdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule : msdq_ram
`default_nettype wire

// File: hdl/message_segmenting_destination_queues_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Message segmenting destination queues
// Per-destination message FIFOs with fixed-size fragment transmission.
//
//   port group    direction  handshake
//   item          in         start high while busy low
//   result        out        strobe, one cycle, no back-pressure
//   cfg_wdata     in         cfg_we, fragment size
//
// A message beat is accepted in S_IDLE and queued in S_MSG unless its
// length is zero or its queue is full. A tick beat visits S_TRD for every
// destination and, for each non-empty one, also S_TCALC, which uses the
// registered read of the queue RAM. Reset clears all control state; queue
// RAM contents are left undefined and are never read before being written.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module message_segmenting_destination_queues_core
	import msdq_pkg::*;
#(
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int DESTINATIONS = DESTINATIONS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire item_t             item,
	input  wire logic              cfg_we,
	input  wire logic [FRAG_W-1:0] cfg_wdata,
	output logic                   strobe,
	output result_t                result
);

	localparam int QW    = $clog2(QUEUE_DEPTH);
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int DW    = $clog2(DESTINATIONS);
	localparam int SW    = QW + 2;
	localparam int AW    = DW + QW;
	localparam int DEPTH = DESTINATIONS * (2 ** QW);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_MSG   = 4'b0010,
		S_TRD   = 4'b0100,
		S_TCALC = 4'b1000
	} state_t;

	state_t            state_q;
	logic [DW-1:0]     d_q;
	logic [DW-1:0]     dest_q;
	logic [LEN_W-1:0]  len_q;
	logic [CW-1:0]     count_q [DESTINATIONS];
	logic [QW-1:0]     head_q  [DESTINATIONS];
	logic [NUM_W-1:0]  mcnt_q  [DESTINATIONS];
	logic [FRAG_W-1:0] frag_q;
	logic [NUM_W-1:0]  dropped_q;
	logic              strobe_q;
	result_t           result_q;

	logic              ram_we;
	logic              ram_re;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	logic [SW-1:0]     slot_sum;
	logic [QW-1:0]     slot;
	logic              full;
	logic [NUM_W-1:0]  mcnt_inc;
	logic [FRAG_W-1:0] frag_max;
	logic [NUM_W-1:0]  rd_num;
	logic [LEN_W-1:0]  rd_rem;
	logic [FRAG_W-1:0] frag_len;
	logic [LEN_W-1:0]  new_rem;
	logic              fin;
	logic              later;
	logic              d_last;
	logic [QW-1:0]     head_inc;

	msdq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	assign slot_sum = SW'(head_q[dest_q]) + SW'(count_q[dest_q]);
	assign slot     = (slot_sum >= SW'(QUEUE_DEPTH)) ? QW'(slot_sum - SW'(QUEUE_DEPTH))
		: QW'(slot_sum);
	assign full     = (count_q[dest_q] == CW'(QUEUE_DEPTH));
	assign mcnt_inc = mcnt_q[dest_q] + NUM_W'(1);

	assign frag_max = (frag_q == '0) ? FRAG_W'(1) : frag_q;
	assign rd_num   = ram_rdata[WORD_W-1:LEN_W];
	assign rd_rem   = ram_rdata[LEN_W-1:0];
	assign frag_len = (rd_rem < LEN_W'(frag_max)) ? FRAG_W'(rd_rem) : frag_max;
	assign new_rem  = rd_rem - LEN_W'(frag_len);
	assign fin      = (new_rem == '0);
	assign d_last   = (d_q == DW'(DESTINATIONS - 1));
	assign head_inc = (head_q[d_q] == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q[d_q] + QW'(1);

	always_comb begin
		later = 1'b0;
		for (int e = 0; e < DESTINATIONS; e++) begin
			if (e > int'(d_q) && count_q[e] != '0) begin
				later = 1'b1;
			end
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = {dest_q, slot};
		ram_wdata = {mcnt_inc, len_q};
		ram_raddr = {d_q, head_q[d_q]};
		unique case (state_q)
			S_MSG: begin
				ram_we = (len_q != '0) && !full;
			end
			S_TRD: begin
				ram_re = (count_q[d_q] != '0);
			end
			S_TCALC: begin
				ram_we    = 1'b1;
				ram_waddr = {d_q, head_q[d_q]};
				ram_wdata = {rd_num, new_rem};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			d_q       <= '0;
			frag_q    <= FRAG_SIZE_RESET;
			dropped_q <= '0;
			strobe_q  <= 1'b0;
			for (int i = 0; i < DESTINATIONS; i++) begin
				count_q[i] <= '0;
				head_q[i]  <= '0;
				mcnt_q[i]  <= '0;
			end
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				frag_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					d_q <= '0;
					if (start) begin
						if (item.mode == MODE_TICK) begin
							state_q <= S_TRD;
						end else if ({1'b0, item.destination} < 3'(DESTINATIONS)) begin
							state_q <= S_MSG;
						end
					end
				end
				S_MSG: begin
					mcnt_q[dest_q] <= mcnt_inc;
					if (len_q != '0) begin
						if (full) begin
							if (dropped_q != '1) begin
								dropped_q <= dropped_q + NUM_W'(1);
							end
						end else begin
							count_q[dest_q] <= count_q[dest_q] + CW'(1);
						end
					end
					state_q <= S_IDLE;
				end
				S_TRD: begin
					if (count_q[d_q] != '0) begin
						state_q <= S_TCALC;
					end else if (d_last) begin
						state_q <= S_IDLE;
					end else begin
						d_q <= d_q + DW'(1);
					end
				end
				S_TCALC: begin
					strobe_q <= 1'b1;
					if (fin) begin
						head_q[d_q]  <= head_inc;
						count_q[d_q] <= count_q[d_q] - CW'(1);
					end
					if (d_last) begin
						state_q <= S_IDLE;
					end else begin
						d_q     <= d_q + DW'(1);
						state_q <= S_TRD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			len_q  <= item.message_length;
			dest_q <= DW'(item.destination);
		end
		if (state_q == S_TCALC) begin
			result_q.out_destination <= DEST_W'(d_q);
			result_q.message_number  <= rd_num;
			result_q.fragment_length <= frag_len;
			result_q.final_fragment  <= fin;
			result_q.last            <= !later;
		end
	end

`ifndef ASSERT_OFF
	a_strobe_from_calc: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == S_TCALC))
		else $error("result strobe without a serving step");

	a_last_ends_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |=> !strobe)
		else $error("result follows the last result of a tick");

	a_dropped_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		dropped_q >= $past(dropped_q))
		else $error("dropped message count decreased");

	a_read_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TCALC) |-> (count_q[d_q] != '0))
		else $error("serving an empty destination queue");
`endif

endmodule : message_segmenting_destination_queues_core
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench: message segmenting destination queues
// Sends message and tick beats through the start/busy handshake. A behavioral
// copy of the destination queues predicts the fragments that each tick must
// emit, and every strobed result is checked in order against them. Directed
// tests cover the corner cases. Random traffic then runs under several
// fragment sizes, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
	import msdq_pkg::*;

	localparam int DEPTH         = QUEUE_DEPTH_DEF;
	localparam int DESTS         = DESTINATIONS_DEF;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int MAX_REPORTS   = 10;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_BEATS   = 51;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	logic              busy;
	item_t             item      = '0;
	logic              cfg_we    = 1'b0;
	logic [FRAG_W-1:0] cfg_wdata = '0;
	logic              strobe;
	result_t           result;

	logic [NUM_W-1:0]  slot_number    [DESTS][DEPTH];
	logic [LEN_W-1:0]  slot_remaining [DESTS][DEPTH];
	int unsigned       q_head  [DESTS];
	int unsigned       q_count [DESTS];
	logic [NUM_W-1:0]  msg_counter [DESTS];
	logic [FRAG_W-1:0] frag_size;

	result_t           pending_frags [$];
	int                mismatch_count = 0;
	int unsigned       cycle_count    = 0;

	message_segmenting_destination_queues_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.strobe    (strobe),
		.result    (result)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic void note_failure(string what, result_t want, result_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("%0t %s: expected dest %0d num %0d len %0d final %0b last %0b",
				$realtime, what, want.out_destination, want.message_number,
				want.fragment_length, want.final_fragment, want.last);
			$display("    got dest %0d num %0d len %0d final %0b last %0b",
				got.out_destination, got.message_number, got.fragment_length,
				got.final_fragment, got.last);
		end
	endfunction

	always @(posedge clk) begin : check_fragments
		result_t want;
		if (arst_n && strobe) begin
			if (pending_frags.size() == 0) begin
				note_failure("unexpected fragment", '0, result);
			end else begin
				want = pending_frags.pop_front();
				if (result.out_destination !== want.out_destination ||
						result.message_number !== want.message_number ||
						result.fragment_length !== want.fragment_length ||
						result.final_fragment !== want.final_fragment ||
						result.last !== want.last)
					note_failure("fragment mismatch", want, result);
			end
		end
	end

	function automatic void predict_fragments(item_t it);
		int unsigned d;
		int unsigned slot;
		int unsigned fmax;
		int unsigned rem;
		int unsigned flen;
		result_t     frag;
		result_t     tick_frags [$];
		if (it.mode == MODE_MESSAGE) begin
			d = it.destination;
			msg_counter[d] = msg_counter[d] + 1'b1;
			if (it.message_length != 0 && q_count[d] < DEPTH) begin
				slot = (q_head[d] + q_count[d]) % DEPTH;
				slot_number[d][slot] = msg_counter[d];
				slot_remaining[d][slot] = it.message_length;
				q_count[d]++;
			end
		end else begin
			fmax = (frag_size == 0) ? 1 : frag_size;
			for (d = 0; d < DESTS; d++) begin
				if (q_count[d] != 0) begin
					rem = slot_remaining[d][q_head[d]];
					flen = (rem < fmax) ? rem : fmax;
					rem = rem - flen;
					slot_remaining[d][q_head[d]] = LEN_W'(rem);
					frag.out_destination = DEST_W'(d);
					frag.message_number = slot_number[d][q_head[d]];
					frag.fragment_length = FRAG_W'(flen);
					frag.final_fragment = (rem == 0);
					frag.last = 1'b0;
					if (rem == 0) begin
						q_head[d] = (q_head[d] + 1) % DEPTH;
						q_count[d]--;
					end
					tick_frags.push_back(frag);
				end
			end
			if (tick_frags.size() != 0)
				tick_frags[tick_frags.size() - 1].last = 1'b1;
			foreach (tick_frags[i])
				pending_frags.push_back(tick_frags[i]);
		end
	endfunction

	function automatic item_t message_beat(int unsigned len, int unsigned dest);
		item_t it;
		it.mode = MODE_MESSAGE;
		it.message_length = LEN_W'(len);
		it.destination = DEST_W'(dest);
		return it;
	endfunction

	function automatic item_t tick_beat();
		item_t it;
		it.mode = MODE_TICK;
		it.message_length = LEN_W'($urandom_range(1023));
		it.destination = DEST_W'($urandom_range(3));
		return it;
	endfunction

	function automatic int unsigned gap_cycles();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 45)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic send_item(item_t it, int unsigned gap);
		item <= it;
		if (!start)
			start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		predict_fragments(it);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_frags.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_fragment_size(logic [FRAG_W-1:0] value);
		wait_idle();
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		frag_size = value;
	endtask

	task automatic drain_queues();
		int unsigned total;
		do begin
			total = 0;
			foreach (q_count[i])
				total += q_count[i];
			if (total != 0)
				send_item(tick_beat(), gap_cycles());
		end while (total != 0);
	endtask

	task automatic test_empty_tick();
		send_item(tick_beat(), gap_cycles());
		send_item(tick_beat(), 0);
	endtask

	task automatic test_default_fragments();
		send_item(message_beat(20, 0), gap_cycles());
		send_item(message_beat(21, 1), 0);
		send_item(message_beat(1, 2), gap_cycles());
		send_item(message_beat(45, 3), 0);
		drain_queues();
	endtask

	task automatic test_zero_length();
		send_item(message_beat(0, 2), 0);
		send_item(message_beat(7, 2), gap_cycles());
		send_item(message_beat(0, 2), 0);
		drain_queues();
	endtask

	task automatic test_longest_message();
		write_fragment_size(8'd255);
		send_item(message_beat(1023, 3), 0);
		send_item(message_beat(1023, 0), gap_cycles());
		send_item(message_beat(255, 1), 0);
		send_item(message_beat(256, 2), 0);
		drain_queues();
	endtask

	task automatic test_fragment_size_zero();
		write_fragment_size(8'd0);
		send_item(message_beat(2, 1), gap_cycles());
		send_item(message_beat(1, 0), 0);
		drain_queues();
	endtask

	task automatic test_queue_overflow();
		write_fragment_size(8'd1);
		repeat (DEPTH + 2)
			send_item(message_beat(1, 1), 0);
		send_item(message_beat(3, 2), gap_cycles());
		drain_queues();
		send_item(message_beat(1, 1), 0);
		drain_queues();
	endtask

	task automatic test_random_traffic();
		int unsigned tick_pct;
		int unsigned r;
		bit          quiet_phase;
		item_t       it;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: write_fragment_size(8'd255);
				1: write_fragment_size(8'd1);
				3: write_fragment_size(8'd0);
				4: write_fragment_size(FRAG_SIZE_RESET);
				default: write_fragment_size(FRAG_W'($urandom_range(2, 254)));
			endcase
			tick_pct = $urandom_range(30, 70);
			quiet_phase = ($urandom_range(2) == 0);
			repeat (PHASE_BEATS) begin
				if ($urandom_range(99) < tick_pct) begin
					it = tick_beat();
				end else begin
					r = $urandom_range(99);
					if (r < 8)
						it = message_beat(0, $urandom_range(3));
					else if (r < 60)
						it = message_beat($urandom_range(1, 60), $urandom_range(3));
					else
						it = message_beat($urandom_range(1, 1023), $urandom_range(3));
				end
				send_item(it, quiet_phase ? 0 : gap_cycles());
			end
		end
	endtask

	initial begin
		frag_size = FRAG_SIZE_RESET;
		foreach (q_head[d]) begin
			q_head[d] = 0;
			q_count[d] = 0;
			msg_counter[d] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_tick();
		test_default_fragments();
		test_zero_length();
		test_longest_message();
		test_fragment_size_zero();
		test_queue_overflow();
		test_random_traffic();
		start <= 1'b0;
		for (int i = 0; i < 2000 && pending_frags.size() != 0; i++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (pending_frags.size() != 0)
			note_failure("missing fragment", pending_frags.pop_front(), '0);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
